// File: rtl/led_strip_effect_engine_core_defines.svh
// ----------------------------------------------------------------------------
// led strip effect engine assertion macros
// shared assertion helpers for the rtl
// ----------------------------------------------------------------------------
`ifndef LED_STRIP_EFFECT_ENGINE_CORE_DEFINES_SVH
`define LED_STRIP_EFFECT_ENGINE_CORE_DEFINES_SVH

// implication checked on every clock edge outside reset
`define LSE_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define LSE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/lse_pkg.sv
// ----------------------------------------------------------------------------
// lse_pkg
// shared constants, types and color helpers of the led strip effect engine
// ----------------------------------------------------------------------------
package lse_pkg;

	localparam int unsigned StripLength = 16;
	localparam int unsigned PixW = (StripLength > 1) ? $clog2(StripLength) : 1;
	localparam int unsigned NumEffects = 6;

	localparam logic [1:0] OP_TICK   = 2'd0;
	localparam logic [1:0] OP_SELECT = 2'd1;
	localparam logic [1:0] OP_NEXT   = 2'd2;

	localparam logic [2:0] FX_RAINBOW = 3'd0;
	localparam logic [2:0] FX_BREATH  = 3'd1;
	localparam logic [2:0] FX_COMET   = 3'd2;
	localparam logic [2:0] FX_WIPE    = 3'd3;
	localparam logic [2:0] FX_FIRE    = 3'd4;
	localparam logic [2:0] FX_SOLID   = 3'd5;

	localparam logic CFG_PEAK = 1'b0;
	localparam logic CFG_SEED = 1'b1;

	localparam logic [7:0]  PEAK_RESET = 8'd64;
	localparam logic [15:0] SEED_RESET = 16'd44257;

	// commands from controller to datapath
	typedef struct packed {
		logic       start_fx;   // compute: effect update pass
		logic       start_clr;  // blank pass
		logic [2:0] fx;
	} lse_cmd_t;

	typedef struct packed {
		logic busy;
		logic done;
	} lse_sts_t;

	function automatic logic [31:0] fx_interval(input logic [2:0] e);
		case (e)
			FX_RAINBOW: fx_interval = 32'd30;
			FX_BREATH:  fx_interval = 32'd15;
			FX_COMET:   fx_interval = 32'd50;
			FX_WIPE:    fx_interval = 32'd80;
			default:    fx_interval = 32'd50;
		endcase
	endfunction

	// x / 255 for x < 65280
	function automatic logic [7:0] div255(input logic [15:0] x);
		logic [16:0] s;
		s = {1'b0, x} + 17'd1 + {9'd0, x[15:8]};
		div255 = s[15:8];
	endfunction

	// hue region 0 to 5 (hue / 43); lse_hsv scales the remainder by 6
	function automatic logic [2:0] hue_region(input logic [7:0] h);
		hue_region = (h < 8'd43) ? 3'd0 : (h < 8'd86) ? 3'd1 : (h < 8'd129) ? 3'd2 :
			(h < 8'd172) ? 3'd3 : (h < 8'd215) ? 3'd4 : 3'd5;
	endfunction

endpackage

// File: rtl/lse_hsv.sv
// ----------------------------------------------------------------------------
// lse_hsv
// two-stage integer hsv to rgb, full saturation
// ----------------------------------------------------------------------------
module lse_hsv (
	input  logic        clk,
	input  logic [7:0]  hue,
	input  logic [7:0]  val,
	output logic [23:0] rgb
);
	import lse_pkg::*;

	logic [2:0]  reg_c;
	logic [7:0]  rem_c;
	logic [10:0] base_c;
	logic [15:0] q_prod, t_prod;
	logic [2:0]  reg_s1;
	logic [7:0]  v_s1;
	logic [15:0] q_s1, t_s1;
	logic [7:0]  q, t;

	always_comb begin
		reg_c  = hue_region(hue);
		base_c = 11'(reg_c) * 11'd43;
		rem_c  = 8'(11'(8'(hue - base_c[7:0])) * 11'd6);
		q_prod = val * (8'd255 - rem_c);
		t_prod = val * rem_c;
	end

	always_ff @(posedge clk) begin
		reg_s1 <= reg_c;
		v_s1   <= val;
		q_s1   <= q_prod;
		t_s1   <= t_prod;
	end

	always_comb begin
		q = div255(q_s1);
		t = div255(t_s1);
		case (reg_s1)
			3'd0:    rgb = {v_s1, t, 8'd0};
			3'd1:    rgb = {q, v_s1, 8'd0};
			3'd2:    rgb = {8'd0, v_s1, t};
			3'd3:    rgb = {8'd0, q, v_s1};
			3'd4:    rgb = {t, 8'd0, v_s1};
			default: rgb = {v_s1, 8'd0, q};
		endcase
	end
endmodule

// File: rtl/lse_datapath.sv
// ----------------------------------------------------------------------------
// lse_datapath
// effect state, frame store and per-pixel compute sweep
// ----------------------------------------------------------------------------
module lse_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  lse_pkg::lse_cmd_t cmd,
	output lse_pkg::lse_sts_t sts,
	input  logic [7:0]        peak_level,
	input  logic              seed_load,
	input  logic [15:0]       seed_value,
	input  logic              out_stall,
	output logic              out_valid,
	output logic [5:0]        pixel_index,
	output logic [7:0]        red,
	output logic [7:0]        green,
	output logic [7:0]        blue,
	output logic              frame_end
);
	import lse_pkg::*;

	localparam logic [PixW-1:0] LastPix = PixW'(StripLength - 1);

	typedef enum logic [1:0] {P_IDLE, P_CALC, P_EMIT} phase_t;

	phase_t          ph_q;
	logic [2:0]      fx_q;
	logic [PixW:0]   cnt_q;       // calc counter, runs one past for hsv latency
	logic [PixW-1:0] emit_q;
	logic [23:0]     store_q [StripLength];

	logic [7:0]  rainbow_hue_q, breath_level_q, comet_hue_q, wipe_hue_q, solid_hue_q;
	logic        breath_falling_q;
	logic [PixW-1:0] comet_pos_q, wipe_pos_q;
	logic [15:0] lfsr_q;
	logic [7:0]  fire_div_q;      // peak - 100 divisor
	logic [15:0] rem_q;           // serial remainder
	logic [4:0]  rem_bit_q;

	logic [7:0]  hue_in;
	logic [23:0] hsv_rgb;
	logic [PixW-1:0] wr_idx;
	logic [PixW:0]   pix_c;

	assign pix_c = cnt_q - (PixW+1)'(1);
	assign wr_idx = pix_c[PixW-1:0];

	always_comb begin
		case (fx_q)
			FX_RAINBOW: hue_in = rainbow_hue_q + 8'({cnt_q[PixW-1:0], 5'd0});
			FX_COMET:   hue_in = comet_hue_q;
			FX_WIPE:    hue_in = wipe_hue_q;
			default:    hue_in = solid_hue_q;
		endcase
	end

	lse_hsv u_hsv (.clk(clk), .hue(hue_in), .val(peak_level), .rgb(hsv_rgb));

	function automatic logic [7:0] sat64(input logic [7:0] c);
		sat64 = (c > 8'd64) ? c - 8'd64 : 8'd0;
	endfunction

	logic [7:0]  lv_next;
	logic [15:0] lfsr_next;
	logic [7:0]  fl;
	logic [15:0] fl_x171;         // fl / 3 as fl * 171 >> 9
	always_comb begin
		lv_next = breath_falling_q ? breath_level_q - 8'd2 : breath_level_q + 8'd2;
		lfsr_next = {1'b0, lfsr_q[15:1]} ^ (lfsr_q[0] ? 16'hB400 : 16'h0000);
		fl = (peak_level > 8'd100) ? 8'd100 + rem_q[7:0] : 8'd100;
		fl_x171 = fl * 8'd171;
	end

	// fire: per pixel a load step, a 16-step restoring remainder and a store step
	logic [16:0] trial;
	assign trial = {rem_q, fire_val_q[15]} - {9'd0, fire_div_q};

	logic [15:0] fire_val_q;
	logic [PixW-1:0] fire_pix_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= P_IDLE;
			fx_q <= FX_RAINBOW;
			cnt_q <= '0;
			emit_q <= '0;
			rainbow_hue_q <= '0; breath_level_q <= '0; breath_falling_q <= 1'b0;
			comet_pos_q <= '0; comet_hue_q <= '0; wipe_pos_q <= '0; wipe_hue_q <= '0;
			solid_hue_q <= '0;
			lfsr_q <= SEED_RESET;
			fire_div_q <= '0;
			rem_q <= '0;
			fire_val_q <= '0;
			rem_bit_q <= '0;
			fire_pix_q <= '0;
			for (int i = 0; i < StripLength; i++) store_q[i] <= '0;
		end else begin
			if (seed_load) lfsr_q <= seed_value;
			unique case (ph_q)
				P_IDLE: begin
					cnt_q <= '0;
					rem_bit_q <= '0;
					fire_pix_q <= '0;
					if (cmd.start_clr) begin
						for (int i = 0; i < StripLength; i++) store_q[i] <= '0;
						emit_q <= '0;
						ph_q <= P_EMIT;
					end else if (cmd.start_fx) begin
						fx_q <= cmd.fx;
						ph_q <= P_CALC;
						fire_div_q <= peak_level - 8'd100;
						if (cmd.fx == FX_BREATH) begin
							breath_level_q <= lv_next;
							if (lv_next == 8'd0) breath_falling_q <= 1'b0;
							else if (lv_next >= peak_level) breath_falling_q <= 1'b1;
						end
						if (cmd.fx == FX_COMET)
							for (int i = 0; i < StripLength; i++)
								store_q[i] <= {sat64(store_q[i][23:16]),
									sat64(store_q[i][15:8]), sat64(store_q[i][7:0])};
					end
				end
				P_CALC: begin
					unique case (fx_q)
						FX_RAINBOW, FX_SOLID: begin
							cnt_q <= cnt_q + 1'b1;
							if (cnt_q != '0) store_q[wr_idx] <= hsv_rgb;
							if (cnt_q != '0 && wr_idx == LastPix) begin
								if (fx_q == FX_RAINBOW) rainbow_hue_q <= rainbow_hue_q + 8'd3;
								else solid_hue_q <= solid_hue_q + 8'd1;
								ph_q <= P_EMIT; emit_q <= '0;
							end
						end
						FX_BREATH: begin
							for (int i = 0; i < StripLength; i++)
								store_q[i] <= {breath_level_q, 8'd0, 1'b0, breath_level_q[7:1]};
							ph_q <= P_EMIT; emit_q <= '0;
						end
						FX_COMET, FX_WIPE: begin
							cnt_q <= cnt_q + 1'b1;
							if (cnt_q == 2) begin
								ph_q <= P_EMIT; emit_q <= '0;
								if (fx_q == FX_COMET) begin
									store_q[comet_pos_q] <= hsv_rgb;
									comet_pos_q <= (comet_pos_q == LastPix) ? '0 : comet_pos_q + 1'b1;
									if (comet_pos_q == LastPix) comet_hue_q <= comet_hue_q + 8'd40;
								end else if (wipe_pos_q == LastPix) begin
									for (int i = 0; i < StripLength; i++) store_q[i] <= '0;
									wipe_pos_q <= '0;
									wipe_hue_q <= wipe_hue_q + 8'd60;
								end else begin
									store_q[wipe_pos_q] <= hsv_rgb;
									wipe_pos_q <= wipe_pos_q + 1'b1;
								end
							end
						end
						default: begin
							// fire: step 0 advances lfsr and loads, steps 1..16 reduce, step 17 stores the pixel
							if (rem_bit_q == 5'd0) begin
								lfsr_q <= lfsr_next;
								fire_val_q <= lfsr_next;
								rem_q <= '0;
								rem_bit_q <= 5'd1;
							end else begin
								rem_q <= trial[16] ? {rem_q[14:0], fire_val_q[15]} : trial[15:0];
								fire_val_q <= {fire_val_q[14:0], 1'b0};
								if (rem_bit_q == 5'd17) begin
									rem_bit_q <= 5'd0;
									store_q[fire_pix_q] <= {fl, 1'b0, fl_x171[15:9], 8'd0};
									fire_pix_q <= fire_pix_q + 1'b1;
									if (fire_pix_q == LastPix) begin
										ph_q <= P_EMIT; emit_q <= '0;
									end
								end else rem_bit_q <= rem_bit_q + 1'b1;
							end
						end
					endcase
				end
				default: begin
					if (!out_stall) begin
						emit_q <= emit_q + 1'b1;
						if (emit_q == LastPix) ph_q <= P_IDLE;
					end
				end
			endcase
		end
	end

	assign out_valid   = (ph_q == P_EMIT);
	assign pixel_index = 6'(emit_q);
	assign red         = store_q[emit_q][23:16];
	assign green       = store_q[emit_q][15:8];
	assign blue        = store_q[emit_q][7:0];
	assign frame_end   = (emit_q == LastPix);
	assign sts.busy    = (ph_q != P_IDLE);
	assign sts.done    = (ph_q == P_EMIT) && !out_stall && (emit_q == LastPix);
endmodule

// File: rtl/lse_ctrl.sv
// ----------------------------------------------------------------------------
// lse_ctrl
// tick bookkeeping, effect selection and command sequencing
// ----------------------------------------------------------------------------
module lse_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        op,
	input  logic [2:0]        effect_choice,
	output lse_pkg::lse_cmd_t cmd,
	input  lse_pkg::lse_sts_t sts
);
	import lse_pkg::*;

	typedef enum logic [1:0] {S_IDLE, S_CHECK, S_WAIT} state_t;

	state_t      state_q;
	logic [31:0] ms_q;
	logic [31:0] stamp_q [NumEffects];
	logic [2:0]  active_q;
	lse_cmd_t    cmd_q;

	assign in_stall = (state_q != S_IDLE);
	assign cmd = cmd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ms_q <= '0;
			for (int i = 0; i < NumEffects; i++) stamp_q[i] <= '0;
			active_q <= FX_RAINBOW;
			cmd_q <= '0;
		end else begin
			cmd_q.start_fx <= 1'b0;
			cmd_q.start_clr <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						unique case (op)
							OP_TICK: begin
								ms_q <= ms_q + 32'd1;
								state_q <= S_CHECK;
							end
							OP_SELECT: begin
								if (effect_choice < 3'(NumEffects)) begin
									active_q <= effect_choice;
									cmd_q.start_clr <= 1'b1;
									state_q <= S_WAIT;
								end
							end
							OP_NEXT: begin
								active_q <= (active_q == 3'(NumEffects - 1)) ? 3'd0 : active_q + 3'd1;
								cmd_q.start_clr <= 1'b1;
								state_q <= S_WAIT;
							end
							default: ;
						endcase
					end
				end
				S_CHECK: begin
					if (ms_q - stamp_q[active_q] >= fx_interval(active_q)) begin
						stamp_q[active_q] <= ms_q;
						cmd_q.start_fx <= 1'b1;
						cmd_q.fx <= active_q;
						state_q <= S_WAIT;
					end else state_q <= S_IDLE;
				end
				default: begin
					if (sts.done) state_q <= S_IDLE;
				end
			endcase
		end
	end
endmodule

// File: rtl/led_strip_effect_engine_core.sv
// ----------------------------------------------------------------------------
// led_strip_effect_engine_core
// six-effect led strip frame generator driven by millisecond ticks
// ----------------------------------------------------------------------------
// channel   direction  signals
// in        slave      in_valid, in_stall, op, effect_choice
// out       master     out_valid, out_stall, pixel_index, red, green, blue, frame_end
// cfg       slave      cfg_valid, cfg_ready, cfg_index, cfg_data
//
// an in-range select or next transaction emits its black frame of StripLength pixels
// once lse_ctrl registers the clear command and the datapath enters its emit phase
// a firing tick is checked, then computes by hsv sweep for rainbow and solid,
// one hsv pixel for comet and wipe, one store fill for breathing or the serial
// remainder unit per pixel for fire, then emits one pixel a cycle while out_stall
// is low; out_stall holds the current pixel; reset clears all effect state and the
// frame store, lfsr takes the seed; input is stalled during a tick check and until a started frame is delivered
module led_strip_effect_engine_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  op,
	input  logic [2:0]  effect_choice,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [5:0]  pixel_index,
	output logic [7:0]  red,
	output logic [7:0]  green,
	output logic [7:0]  blue,
	output logic        frame_end,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);
	import lse_pkg::*;

	`include "led_strip_effect_engine_core_defines.svh"

	lse_cmd_t   cmd;
	lse_sts_t   sts;
	logic [7:0] peak_q;
	logic       seed_load;

	// configuration registers, always writable
	assign cfg_ready = 1'b1;
	assign seed_load = cfg_valid && (cfg_index == CFG_SEED);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_q <= PEAK_RESET;
		end else if (cfg_valid && cfg_index == CFG_PEAK) begin
			peak_q <= cfg_data[7:0];
		end
	end

	lse_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.op(op), .effect_choice(effect_choice), .cmd(cmd), .sts(sts)
	);

	lse_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts), .peak_level(peak_q),
		.seed_load(seed_load), .seed_value(cfg_data), .out_stall(out_stall),
		.out_valid(out_valid), .pixel_index(pixel_index), .red(red), .green(green),
		.blue(blue), .frame_end(frame_end)
	);

	// no input transaction while a frame is still being shown
	`LSE_ASSERT_IMP(a_no_in_during_out, clk, arst_n, out_valid, in_stall, "input open during frame")
	// a frame end transaction closes the frame
	`LSE_ASSERT_NEXT(a_frame_closes, clk, arst_n, out_valid && !out_stall && frame_end, !out_valid, "frame did not close")
	// pixel index walks forward by one per transaction
	`LSE_ASSERT_NEXT(a_pixel_step, clk, arst_n, out_valid && !out_stall && !frame_end, out_valid && pixel_index == $past(pixel_index) + 6'd1, "pixel index skipped")
endmodule

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the led strip effect engine: a behavioral
// predictor of the six effects computes every frame pixel, a clocked
// driver and monitor move transactions with random gaps and stalls
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import lse_pkg::*;

	typedef struct packed {
		logic [1:0] op;
		logic [2:0] choice;
	} strip_cmd_t;

	typedef struct packed {
		logic [5:0] idx;
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		logic       last;
	} pixel_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  op = OP_TICK;
	logic [2:0]  effect_choice = FX_RAINBOW;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [5:0]  pixel_index;
	logic [7:0]  red, green, blue;
	logic        frame_end;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_index = CFG_PEAK;
	logic [15:0] cfg_data = 16'd0;

	led_strip_effect_engine_core dut (.*);

	always #4 clk = ~clk;

	// predictor state
	logic [7:0]  peak;
	logic [31:0] ms_count;
	logic [31:0] last_fire [NumEffects];
	logic [2:0]  cur_fx;
	logic [7:0]  rb_hue, br_level, comet_hue_q, wipe_hue_q, solid_hue_q;
	logic        br_down;
	logic [5:0]  comet_at, wipe_at;
	logic [15:0] flicker;
	logic [23:0] frame [StripLength];

	strip_cmd_t cmd_q [$];
	pixel_t     pixels_due [$];
	int         errors = 0;
	int         frames_seen = 0;
	int         pixels_seen = 0;
	bit         hold_out = 1'b0;
	bit         burst_mode = 1'b0;

	function automatic logic [23:0] hsv_px(input logic [7:0] h);
		int v, reg_n, rem, q, t;
		v = peak;
		reg_n = h / 43;
		rem = ((h - reg_n * 43) * 6) & 255;
		q = (v * (255 - rem)) / 255;
		t = (v * rem) / 255;
		case (reg_n)
			0: return {8'(v), 8'(t), 8'd0};
			1: return {8'(q), 8'(v), 8'd0};
			2: return {8'd0, 8'(v), 8'(t)};
			3: return {8'd0, 8'(q), 8'(v)};
			4: return {8'(t), 8'd0, 8'(v)};
			default: return {8'(v), 8'd0, 8'(q)};
		endcase
	endfunction

	function automatic logic [7:0] fade64(input logic [7:0] c);
		return (c > 8'd64) ? c - 8'd64 : 8'd0;
	endfunction

	task automatic reset_model();
		peak = PEAK_RESET;
		flicker = SEED_RESET;
		ms_count = 0;
		foreach (last_fire[k]) last_fire[k] = 0;
		cur_fx = FX_RAINBOW;
		{rb_hue, br_level, comet_hue_q, wipe_hue_q, solid_hue_q} = '0;
		br_down = 0;
		comet_at = 0;
		wipe_at = 0;
		foreach (frame[k]) frame[k] = '0;
	endtask

	task automatic queue_frame();
		pixel_t p;
		for (int i = 0; i < StripLength; i++) begin
			p.idx = 6'(i);
			{p.r, p.g, p.b} = frame[i];
			p.last = (i == StripLength - 1);
			pixels_due.push_back(p);
		end
	endtask

	task automatic advance_effect();
		logic [23:0] c;
		int f;
		case (cur_fx)
			FX_RAINBOW: begin
				for (int i = 0; i < StripLength; i++)
					frame[i] = hsv_px(rb_hue + 8'(32 * i));
				rb_hue += 8'd3;
			end
			FX_BREATH: begin
				br_level = br_down ? br_level - 8'd2 : br_level + 8'd2;
				if (br_level >= peak) br_down = 1;
				if (br_level == 0) br_down = 0;
				for (int i = 0; i < StripLength; i++)
					frame[i] = {br_level, 8'd0, br_level >> 1};
			end
			FX_COMET: begin
				for (int i = 0; i < StripLength; i++)
					frame[i] = {fade64(frame[i][23:16]), fade64(frame[i][15:8]),
						fade64(frame[i][7:0])};
				frame[comet_at] = hsv_px(comet_hue_q);
				comet_at = 6'((comet_at + 1) % StripLength);
				if (comet_at == 0) comet_hue_q += 8'd40;
			end
			FX_WIPE: begin
				frame[wipe_at] = hsv_px(wipe_hue_q);
				wipe_at++;
				if (wipe_at >= StripLength) begin
					wipe_at = 0;
					wipe_hue_q += 8'd60;
					foreach (frame[k]) frame[k] = '0;
				end
			end
			FX_FIRE: begin
				for (int i = 0; i < StripLength; i++) begin
					flicker = flicker[0] ? ((flicker >> 1) ^ 16'hB400) : (flicker >> 1);
					f = (peak > 100) ? 100 + flicker % (peak - 100) : 100;
					frame[i] = {8'(f), 8'(f / 3), 8'd0};
				end
			end
			default: begin
				c = hsv_px(solid_hue_q);
				foreach (frame[k]) frame[k] = c;
				solid_hue_q += 8'd1;
			end
		endcase
	endtask

	task automatic predict_strip(input strip_cmd_t cm);
		case (cm.op)
			OP_TICK: begin
				ms_count++;
				if (ms_count - last_fire[cur_fx] >= fx_interval(cur_fx)) begin
					last_fire[cur_fx] = ms_count;
					advance_effect();
					queue_frame();
				end
			end
			OP_SELECT: if (cm.choice < NumEffects) begin
				cur_fx = cm.choice;
				foreach (frame[k]) frame[k] = '0;
				queue_frame();
			end
			OP_NEXT: begin
				cur_fx = 3'((cur_fx + 1) % NumEffects);
				foreach (frame[k]) frame[k] = '0;
				queue_frame();
			end
			default: ;
		endcase
	endtask

	// driver: gaps mostly short, a few long; payload held while stalled
	int gap_left = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				predict_strip('{op: op, choice: effect_choice});
				gap_left = burst_mode ? 0 :
					(($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2));
			end
			if (!in_valid || !in_stall) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (cmd_q.size() > 0) begin
					strip_cmd_t nx;
					nx = cmd_q.pop_front();
					in_valid <= 1'b1;
					op <= nx.op;
					effect_choice <= nx.choice;
				end else
					in_valid <= 1'b0;
			end
		end
	end

	// monitor: compare each accepted pixel with the oldest predicted one, and drive random output stalls
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			pixel_t e;
			if (pixels_due.size() == 0) begin
				errors++;
				$display("%0t: unexpected pixel idx %0d", $realtime, pixel_index);
			end else begin
				e = pixels_due.pop_front();
				if (e !== {pixel_index, red, green, blue, frame_end}) begin
					errors++;
					$display("%0t: pixel mismatch exp idx %0d rgb %h%h%h end %b, got idx %0d rgb %h%h%h end %b",
						$realtime, e.idx, e.r, e.g, e.b, e.last,
						pixel_index, red, green, blue, frame_end);
				end
				pixels_seen++;
				if (frame_end) frames_seen++;
			end
		end
		if (arst_n)
			out_stall <= hold_out ? 1'b1 :
				(($urandom_range(0, 3) == 0) ? (($urandom_range(0, 15) == 0) ? 1'b1 : 1'b0) : 1'b0)
				| ($urandom_range(0, 5) == 0);
	end

	task automatic write_reg(input logic idx, input logic [15:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == CFG_PEAK) peak = val[7:0];
		else flicker = val;
	endtask

	task automatic drain();
		while (cmd_q.size() > 0 || in_valid || pixels_due.size() > 0) @(posedge clk);
		// no pass is still running here; the extra wait only adds idle margin
		repeat (400) @(posedge clk);
	endtask

	function automatic strip_cmd_t rand_cmd();
		strip_cmd_t c;
		int r;
		r = $urandom_range(0, 99);
		c.choice = 3'($urandom);
		if (r < 88) c.op = OP_TICK;
		else if (r < 94) c.op = OP_SELECT;
		else if (r < 98) c.op = OP_NEXT;
		else c.op = 2'd3;
		return c;
	endfunction

	task automatic push_ticks(input int n);
		repeat (n) cmd_q.push_back('{op: OP_TICK, choice: 3'($urandom)});
	endtask

	initial begin
		logic [15:0] seeds [4];
		logic [7:0]  peaks [4];
		reset_model();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: every op, out-of-range selects, unused op, non-firing rainbow ticks
		for (int k = 0; k < 8; k++) cmd_q.push_back('{op: OP_SELECT, choice: 3'(k)});
		cmd_q.push_back('{op: 2'd3, choice: 3'd7});
		cmd_q.push_back('{op: OP_NEXT, choice: 3'd0});
		cmd_q.push_back('{op: OP_SELECT, choice: FX_RAINBOW});
		push_ticks(14);
		drain();

		// pause the sender: a long receiver hold-off while ticks fire breathing
		cmd_q.push_back('{op: OP_SELECT, choice: FX_BREATH});
		burst_mode = 1;
		push_ticks(40);
		hold_out = 1;
		repeat (300) @(posedge clk);
		hold_out = 0;
		drain();
		burst_mode = 0;

		peaks = '{8'd255, 8'd0, 8'd101, 8'd180};
		seeds = '{16'd1, 16'hFFFF, 16'd0, 16'h1234};
		for (int ph = 0; ph < 4; ph++) begin
			write_reg(CFG_PEAK, {8'($urandom), peaks[ph]});
			write_reg(CFG_SEED, seeds[ph]);
			cmd_q.push_back('{op: OP_SELECT, choice: 3'(ph + 2 + (ph == 3 ? -2 : 0))});
			cmd_q.push_back('{op: OP_SELECT, choice: FX_FIRE});
			push_ticks(5);
			repeat (49) cmd_q.push_back(rand_cmd());
			drain();
		end
		// back to the reset peak level, then select wipe and send ticks
		write_reg(CFG_PEAK, 16'd64);
		cmd_q.push_back('{op: OP_SELECT, choice: FX_WIPE});
		push_ticks(20);
		drain();

		$display("covered %0d frames, %0d pixels across all effects, ops and peak/seed extremes",
			frames_seen, pixels_seen);
		if (errors == 0)
			$display("** led_strip_effect_engine_core: PASSED **");
		else
			$display("** led_strip_effect_engine_core: FAILED **");
		$finish;
	end

	initial begin
		#20ms;
		$display("** led_strip_effect_engine_core: FAILED **");
		$finish;
	end
endmodule
